// ----- hdl/tbrl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbrl_pkg
// Shared types and constants for the token bucket rate limiter.
// ----------------------------------------------------------------------------
package tbrl_pkg;

	localparam int STAMP_W    = 63;
	localparam int PERIOD_W   = 40;
	localparam int CAPY_W     = 16;
	localparam int TOK_W      = 32;
	localparam int TOL_W      = 40;
	localparam int QUO_W      = 33;
	localparam int ALU_W      = 66;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;

	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_RESET = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_TOK = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd3;

	localparam logic [PERIOD_W-1:0] PERIOD_RST   = 40'd1000000000;
	localparam logic [CAPY_W-1:0]   CAPACITY_RST = 16'd1;
	localparam logic [TOK_W-1:0]    INIT_TOK_RST = 32'd65536;
	localparam logic [TOL_W-1:0]    TOL_RST      = 40'd0;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_ns;
		logic [CAPY_W-1:0]   bucket_capacity;
		logic [TOK_W-1:0]    initial_tokens_q16;
		logic [TOL_W-1:0]    jump_back_tolerance_ns;
	} cfg_t;

	typedef struct packed {
		logic             sub;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             borrow;
	} alu_rsp_t;

endpackage

// ----- hdl/tbrl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbrl_if
// Valid/ready channels carrying check items and their results.
// ----------------------------------------------------------------------------
interface tbrl_item_if;
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [tbrl_pkg::STAMP_W-1:0] stamp_ns;

	modport source (output valid, output opcode, output stamp_ns, input ready);
	modport sink (input valid, input opcode, input stamp_ns, output ready);
endinterface

interface tbrl_result_if;
	logic valid;
	logic ready;
	logic allow;

	modport source (output valid, output allow, input ready);
	modport sink (input valid, input allow, output ready);
endinterface

// ----- hdl/tbrl_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbrl_cfg
// Configuration register file, written by index, reset to the defaults.
// ----------------------------------------------------------------------------
module tbrl_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [tbrl_pkg::CFG_IDX_W-1:0]  index,
	input  logic [tbrl_pkg::CFG_DATA_W-1:0] data,
	output tbrl_pkg::cfg_t                  cfg
);

	tbrl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_ns              <= tbrl_pkg::PERIOD_RST;
			cfg_q.bucket_capacity        <= tbrl_pkg::CAPACITY_RST;
			cfg_q.initial_tokens_q16     <= tbrl_pkg::INIT_TOK_RST;
			cfg_q.jump_back_tolerance_ns <= tbrl_pkg::TOL_RST;
		end else if (we) begin
			case (index)
				tbrl_pkg::REG_PERIOD: begin
					cfg_q.period_ns <= data[tbrl_pkg::PERIOD_W-1:0];
				end
				tbrl_pkg::REG_CAPACITY: begin
					cfg_q.bucket_capacity <= data[tbrl_pkg::CAPY_W-1:0];
				end
				tbrl_pkg::REG_INIT_TOK: begin
					cfg_q.initial_tokens_q16 <= data[tbrl_pkg::TOK_W-1:0];
				end
				tbrl_pkg::REG_TOLERANCE: begin
					cfg_q.jump_back_tolerance_ns <= data[tbrl_pkg::TOL_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/tbrl_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbrl_alu
// Shared add/subtract unit; reports a borrow when a subtrahend exceeds a.
// ----------------------------------------------------------------------------
module tbrl_alu (
	input  tbrl_pkg::alu_req_t req,
	output tbrl_pkg::alu_rsp_t rsp
);

	logic [tbrl_pkg::ALU_W-1:0] b_eff;
	logic [tbrl_pkg::ALU_W:0]   sum;

	always_comb begin
		b_eff = req.sub ? ~req.b : req.b;
		sum   = {1'b0, req.a} + {1'b0, b_eff} + {{tbrl_pkg::ALU_W{1'b0}}, req.sub};
		rsp.res    = sum[tbrl_pkg::ALU_W-1:0];
		// carry out of a + ~b + 1 is clear exactly when a < b
		rsp.borrow = req.sub & ~sum[tbrl_pkg::ALU_W];
	end

endmodule

// ----- hdl/token_bucket_rate_limiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter
// Token bucket check of message timestamps; one allow/deny result per item.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload              Handshake
// item     in   opcode, stamp_ns     valid/ready, transfer when both high
// result   out  allow                valid/ready, transfer when both high
// cfg      in   cfg_index, cfg_data  cfg_we, written on the clock edge
//
// A reset item sends the sequencer straight to its final step; a check takes
// one of the short paths, or refills through the divider: 33 restoring steps
// of the shared subtractor, one quotient bit each. The result is registered
// and raised as the sequencer leaves its final step.
// All adds and subtracts go through the one add/subtract unit, one step a cycle.
// item.ready is high only while no item is in flight; a stalled result holds
// in its output register and the next item is taken meanwhile, but that item
// waits in its final step until the output register is free.
// arst_n resets the sequencer, the bucket state and the configuration to their reset values.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter #(
	parameter int TOKEN_FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tbrl_item_if.sink                       item,
	tbrl_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [tbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbrl_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW     = tbrl_pkg::ALU_W;
	localparam int TW     = tbrl_pkg::TOK_W;
	localparam int PW     = tbrl_pkg::PERIOD_W;
	localparam int SAT_SH = tbrl_pkg::QUO_W - TOKEN_FRAC_BITS;
	localparam int CAPF_W = (tbrl_pkg::CAPY_W + TOKEN_FRAC_BITS > TW) ?
		tbrl_pkg::CAPY_W + TOKEN_FRAC_BITS : TW + 1;
	localparam logic [TW-1:0] ONE_FX = TW'(64'd1 << TOKEN_FRAC_BITS);
	localparam logic [TW-1:0] TOK_RST =
		(tbrl_pkg::INIT_TOK_RST < ONE_FX) ? tbrl_pkg::INIT_TOK_RST : ONE_FX;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIFF  = 4'd1;
	localparam logic [3:0] ST_DT    = 4'd2;
	localparam logic [3:0] ST_JUMP  = 4'd3;
	localparam logic [3:0] ST_SAT   = 4'd4;
	localparam logic [3:0] ST_DIV   = 4'd5;
	localparam logic [3:0] ST_ADD   = 4'd6;
	localparam logic [3:0] ST_CAP   = 4'd7;
	localparam logic [3:0] ST_SPEND = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	tbrl_pkg::cfg_t     cfg;
	tbrl_pkg::alu_req_t alu_req;
	tbrl_pkg::alu_rsp_t alu_rsp;

	logic [3:0]                     state_q;
	logic [tbrl_pkg::STAMP_W-1:0]   last_q;
	logic [TW-1:0]                  tok_q;
	logic [tbrl_pkg::STAMP_W-1:0]   stamp_q;
	logic [AW-1:0]                  acc_q;
	logic [PW-1:0]                  rem_q;
	logic [tbrl_pkg::QUO_W-1:0]     quo_q;
	logic [tbrl_pkg::QUO_W-1:0]     nlo_q;
	logic [5:0]                     cnt_q;
	logic                           allow_q;
	logic                           out_valid_q;
	logic                           out_allow_q;

	logic [CAPF_W-1:0] cap_wide;
	logic [TW-1:0]     cap_fixed;
	logic [TW-1:0]     init_fill;
	logic [AW-1:0]     dt_shr;
	logic [AW-1:0]     dt_shl;
	logic              accept;
	logic              load_out;

	tbrl_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.index (cfg_index),
		.data  (cfg_data),
		.cfg   (cfg)
	);

	tbrl_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	always_comb begin
		cap_wide  = CAPF_W'(cfg.bucket_capacity) << TOKEN_FRAC_BITS;
		cap_fixed = (cap_wide > CAPF_W'({TW{1'b1}})) ? {TW{1'b1}} : cap_wide[TW-1:0];
		init_fill = (cfg.initial_tokens_q16 < cap_fixed) ? cfg.initial_tokens_q16 : cap_fixed;
		dt_shr    = acc_q >> SAT_SH;
		dt_shl    = acc_q << TOKEN_FRAC_BITS;
	end

	assign accept   = item.valid && item.ready;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	assign item.ready   = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.allow = out_allow_q;

	// operand select for the shared unit
	always_comb begin
		alu_req.sub = 1'b1;
		alu_req.a   = '0;
		alu_req.b   = '0;
		case (state_q)
			ST_DIFF: begin
				alu_req.a = AW'(last_q);
				alu_req.b = AW'(stamp_q);
			end
			ST_DT: begin
				alu_req.a = AW'(stamp_q);
				alu_req.b = AW'(last_q);
			end
			ST_JUMP: begin
				alu_req.a = AW'(cfg.jump_back_tolerance_ns);
				alu_req.b = acc_q;
			end
			ST_SAT: begin
				alu_req.a = acc_q;
				alu_req.b = AW'(cfg.period_ns) << SAT_SH;
			end
			ST_DIV: begin
				alu_req.a = AW'({rem_q, nlo_q[tbrl_pkg::QUO_W-1]});
				alu_req.b = AW'(cfg.period_ns);
			end
			ST_ADD: begin
				alu_req.sub = 1'b0;
				alu_req.a   = AW'(tok_q);
				alu_req.b   = AW'(quo_q);
			end
			ST_CAP: begin
				alu_req.a = acc_q;
				alu_req.b = AW'(cap_fixed);
			end
			ST_SPEND: begin
				alu_req.a = acc_q;
				alu_req.b = AW'(ONE_FX);
			end
			default: begin
				alu_req.sub = 1'b1;
			end
		endcase
	end

	// sequencer and bucket state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= '0;
			tok_q       <= TOK_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.opcode == tbrl_pkg::OP_RESET) begin
							last_q  <= '0;
							tok_q   <= init_fill;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DIFF;
						end
					end
				end
				ST_DIFF: begin
					if (last_q == '0) begin
						last_q  <= stamp_q;
						state_q <= ST_ADD;
					end else if (alu_rsp.borrow) begin
						state_q <= ST_DT;
					end else if (alu_rsp.res == '0) begin
						state_q <= ST_ADD;
					end else begin
						state_q <= ST_JUMP;
					end
				end
				ST_DT: begin
					last_q  <= stamp_q;
					state_q <= (cfg.period_ns == '0) ? ST_SPEND : ST_SAT;
				end
				ST_JUMP: begin
					last_q <= stamp_q;
					if (alu_rsp.borrow) begin
						tok_q   <= init_fill;
						state_q <= ST_ADD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SAT: begin
					state_q <= alu_rsp.borrow ? ST_DIV : ST_SPEND;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					state_q <= ST_SPEND;
				end
				ST_SPEND: begin
					tok_q   <= alu_rsp.borrow ? acc_q[TW-1:0] : alu_rsp.res[TW-1:0];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of the datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					stamp_q <= item.stamp_ns;
					allow_q <= 1'b0;
				end
			end
			ST_DIFF: begin
				acc_q <= alu_rsp.res;
				quo_q <= '0;
			end
			ST_DT: begin
				// zero period refills the bucket outright
				acc_q <= (cfg.period_ns == '0) ? AW'(cap_fixed) : alu_rsp.res;
			end
			ST_JUMP: begin
				quo_q   <= '0;
				allow_q <= 1'b0;
			end
			ST_SAT: begin
				if (alu_rsp.borrow) begin
					rem_q <= dt_shr[PW-1:0];
					nlo_q <= dt_shl[tbrl_pkg::QUO_W-1:0];
					cnt_q <= 6'(tbrl_pkg::QUO_W - 1);
				end else begin
					acc_q <= AW'(cap_fixed);
				end
			end
			ST_DIV: begin
				if (alu_rsp.borrow) begin
					rem_q <= {rem_q[PW-2:0], nlo_q[tbrl_pkg::QUO_W-1]};
				end else begin
					rem_q <= alu_rsp.res[PW-1:0];
				end
				quo_q <= {quo_q[tbrl_pkg::QUO_W-2:0], ~alu_rsp.borrow};
				nlo_q <= {nlo_q[tbrl_pkg::QUO_W-2:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
			end
			ST_ADD: begin
				acc_q <= alu_rsp.res;
			end
			ST_CAP: begin
				if (!alu_rsp.borrow) begin
					acc_q <= AW'(cap_fixed);
				end
			end
			ST_SPEND: begin
				allow_q <= ~alu_rsp.borrow;
			end
			ST_DONE: begin
				if (load_out) begin
					out_allow_q <= allow_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	a_rem_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < cfg.period_ns)
		else $error("divider remainder not below period");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && cnt_q == '0 |=> state_q == ST_ADD)
		else $error("divider did not hand over after the last step");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the done step");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted item did not start the sequencer");

endmodule
